/* hw/rtl/bph_pkg.sv */
// Shared types, constants and helper functions of the Bezier point and heading unit.
// No dependencies; every other file depends on this package.
package bph_pkg;

  localparam int CoordW = 32;
  localparam int TW = 17;
  localparam int CntW = 2;
  localparam int HeadW = 16;
  localparam logic [TW-1:0] TOne = 17'h10000;

  localparam int LerpPW = 51;
  localparam int VecW = 64;
  localparam int CordicW = 34;
  localparam int CordicSteps = 28;
  localparam int CordicPerStage = 2;
  localparam int CordicStages = CordicSteps / CordicPerStage;
  localparam int PointStages = 6;
  localparam int NormStages = 3;
  localparam int NormTop = 29;
  localparam int ShiftW = 6;

  typedef enum logic [CntW-1:0] {
    CntLine  = 2'd0,
    CntQuad  = 2'd1,
    CntCubic = 2'd2,
    CntBad   = 2'd3
  } cnt_e;

  typedef struct packed {
    logic [TW-1:0]            t_param;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] ctrl0_x;
    logic signed [CoordW-1:0] ctrl0_y;
    logic signed [CoordW-1:0] ctrl1_x;
    logic signed [CoordW-1:0] ctrl1_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    cnt_e                     ctrl_count;
  } req_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic                   zero;
  } dvec_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
  } cvec_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  function automatic logic signed [LerpPW-1:0] lerp_prod(input logic signed [CoordW-1:0] a,
                                                         input logic signed [CoordW-1:0] b,
                                                         input logic [TW-1:0] t);
    logic signed [CoordW:0] d;
    d = (CoordW+1)'(b) - (CoordW+1)'(a);
    return d * $signed({1'b0, t});
  endfunction

  function automatic logic signed [CoordW-1:0] lerp_sum(input logic signed [CoordW-1:0] a,
                                                        input logic signed [LerpPW-1:0] p);
    logic signed [LerpPW-1:0] r;
    r = (p + LerpPW'(32768)) >>> 16;
    return a + r[CoordW-1:0];
  endfunction

  function automatic logic signed [CordicW-1:0] atan_lut(input int unsigned i);
    logic signed [CordicW-1:0] v;
    unique case (i)
      0: v = 34'sd536870912;
      1: v = 34'sd316933406;
      2: v = 34'sd167458907;
      3: v = 34'sd85004756;
      4: v = 34'sd42667331;
      5: v = 34'sd21354465;
      6: v = 34'sd10680094;
      7: v = 34'sd5340245;
      8: v = 34'sd2670163;
      9: v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/bph_in_if.sv */
// Request channel of the Bezier point and heading unit: valid, ready and payload.
// Depends on bph_pkg for field widths.
interface bph_in_if;
  logic                             valid;
  logic                             ready;
  logic [bph_pkg::TW-1:0]           t_param;
  logic signed [bph_pkg::CoordW-1:0] start_x;
  logic signed [bph_pkg::CoordW-1:0] start_y;
  logic signed [bph_pkg::CoordW-1:0] ctrl0_x;
  logic signed [bph_pkg::CoordW-1:0] ctrl0_y;
  logic signed [bph_pkg::CoordW-1:0] ctrl1_x;
  logic signed [bph_pkg::CoordW-1:0] ctrl1_y;
  logic signed [bph_pkg::CoordW-1:0] end_x;
  logic signed [bph_pkg::CoordW-1:0] end_y;
  logic [bph_pkg::CntW-1:0]         ctrl_count;

  modport source (output valid, t_param, start_x, start_y, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y,
                  end_x, end_y, ctrl_count, input ready);
  modport sink (input valid, t_param, start_x, start_y, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y,
                end_x, end_y, ctrl_count, output ready);
  modport monitor (input valid, ready, t_param, start_x, start_y, ctrl0_x, ctrl0_y, ctrl1_x,
                   ctrl1_y, end_x, end_y, ctrl_count);
endinterface

/* hw/rtl/bph_out_if.sv */
// Result channel of the Bezier point and heading unit: valid, ready and payload.
// Depends on bph_pkg for field widths.
interface bph_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bph_pkg::CoordW-1:0] point_x;
  logic signed [bph_pkg::CoordW-1:0] point_y;
  logic signed [bph_pkg::HeadW-1:0]  heading;

  modport source (output valid, point_x, point_y, heading, input ready);
  modport sink (input valid, point_x, point_y, heading, output ready);
  modport monitor (input valid, ready, point_x, point_y, heading);
endinterface

/* hw/rtl/bezier_point_and_heading_unit.sv */
// Top level of the Bezier point and heading unit: pipeline control, delay lines, output register.
// Depends on bph_pkg, bph_in_if, bph_out_if, bph_point, bph_deriv, bph_norm, bph_cordic.
//
//   channel  dir  payload                                             handshake
//   req_i    in   t_param, start/ctrl0/ctrl1/end x and y, ctrl_count  valid/ready
//   rsp_o    out  point_x, point_y, heading                           valid/ready
//
// The path from request to result runs through the 6-stage point and derivative datapaths,
// the 3-stage normalizer and the 15-stage CORDIC, plus the output register.
// One request is taken every cycle while the result side takes results.
// Reset clears only the valid bits; the pipeline is empty after reset.
// A stall at the output freezes every stage, so nothing is lost or repeated.
module bezier_point_and_heading_unit #(
  parameter int ANGLE_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  bph_in_if.sink     req_i,
  bph_out_if.source  rsp_o
);
  import bph_pkg::*;

  localparam int DlyLen = NormStages + CordicStages + 1;
  localparam int Depth = PointStages + DlyLen + 1;
  localparam int Sh = CoordW - ANGLE_BITS;

  logic adv;
  logic [Depth-1:0] vld_q;
  req_t req;
  point_t pt;
  dvec_t dvec;
  cvec_t cvec;
  logic signed [CordicW-1:0] acc, acc_r, hsh;
  logic signed [ANGLE_BITS-1:0] ha;
  logic signed [39:0] hext;
  point_t pt_q [DlyLen];
  logic zero_q [DlyLen];
  point_t out_pt_q;
  logic signed [HeadW-1:0] out_head_q;

  assign adv = !vld_q[Depth-1] || rsp_o.ready;
  assign req_i.ready = adv;

  assign req.t_param = req_i.t_param;
  assign req.start_x = req_i.start_x;
  assign req.start_y = req_i.start_y;
  assign req.ctrl0_x = req_i.ctrl0_x;
  assign req.ctrl0_y = req_i.ctrl0_y;
  assign req.ctrl1_x = req_i.ctrl1_x;
  assign req.ctrl1_y = req_i.ctrl1_y;
  assign req.end_x = req_i.end_x;
  assign req.end_y = req_i.end_y;
  assign req.ctrl_count = cnt_e'(req_i.ctrl_count);

  bph_point u_point (.clk_i, .en_i(adv), .req_i(req), .pt_o(pt));
  bph_deriv u_deriv (.clk_i, .en_i(adv), .req_i(req), .vec_o(dvec));
  bph_norm u_norm (.clk_i, .en_i(adv), .vec_i(dvec), .vec_o(cvec));
  bph_cordic u_cordic (.clk_i, .en_i(adv), .vec_i(cvec), .acc_o(acc));

  assign acc_r = acc + (CordicW'(1) <<< (Sh - 1));
  assign hsh = acc_r >>> Sh;
  assign ha = hsh[ANGLE_BITS-1:0];
  assign hext = 40'(ha);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q[0] <= pt;
      zero_q[0] <= dvec.zero;
      for (int i = 1; i < DlyLen; i++) begin
        pt_q[i] <= pt_q[i-1];
        zero_q[i] <= zero_q[i-1];
      end
      out_pt_q <= pt_q[DlyLen-1];
      out_head_q <= zero_q[DlyLen-1] ? '0 : hext[HeadW-1:0];
    end
  end

  assign rsp_o.valid = vld_q[Depth-1];
  assign rsp_o.point_x = out_pt_q.x;
  assign rsp_o.point_y = out_pt_q.y;
  assign rsp_o.heading = out_head_q;
endmodule

/* hw/rtl/bph_point.sv */
// Six-stage de Casteljau point pipeline, one lerp level per two stages.
// Depends on bph_pkg.
module bph_point (
  input  logic             clk_i,
  input  logic             en_i,
  input  bph_pkg::req_t    req_i,
  output bph_pkg::point_t  pt_o
);
  import bph_pkg::*;

  logic [TW-1:0] t_c;
  logic signed [CoordW-1:0] res [2];

  assign t_c = (req_i.t_param > TOne) ? TOne : req_i.t_param;

  for (genvar g = 0; g < 2; g++) begin : g_axis
    logic signed [CoordW-1:0] p0, c0, c1, p1;
    logic signed [CoordW-1:0] base1_q [3];
    logic signed [LerpPW-1:0] prod1_q [3];
    logic signed [CoordW-1:0] r2_q [3];
    logic signed [CoordW-1:0] base3_q [2];
    logic signed [LerpPW-1:0] prod3_q [2];
    logic signed [CoordW-1:0] r4_q [2];
    logic signed [CoordW-1:0] base5_q;
    logic signed [LerpPW-1:0] prod5_q;
    logic signed [CoordW-1:0] r6_q;
    logic [TW-1:0] t1_q, t2_q, t3_q, t4_q;
    cnt_e cnt1_q, cnt2_q, cnt3_q, cnt4_q;
    logic signed [CoordW-1:0] b0, b1, m0b, f1b;

    assign p0 = (g == 0) ? req_i.start_x : req_i.start_y;
    assign c0 = (g == 0) ? req_i.ctrl0_x : req_i.ctrl0_y;
    assign c1 = (g == 0) ? req_i.ctrl1_x : req_i.ctrl1_y;
    assign p1 = (g == 0) ? req_i.end_x : req_i.end_y;
    assign b0 = (req_i.ctrl_count == CntQuad || req_i.ctrl_count == CntCubic) ? c0 : p1;
    assign b1 = (req_i.ctrl_count == CntCubic) ? c1 : p1;
    assign m0b = (cnt2_q == CntQuad || cnt2_q == CntCubic) ? r2_q[1] : r2_q[0];
    assign f1b = (cnt4_q == CntCubic) ? r4_q[1] : r4_q[0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        base1_q[0] <= p0;
        base1_q[1] <= c0;
        base1_q[2] <= c1;
        prod1_q[0] <= lerp_prod(p0, b0, t_c);
        prod1_q[1] <= lerp_prod(c0, b1, t_c);
        prod1_q[2] <= lerp_prod(c1, p1, t_c);
        t1_q <= t_c;
        cnt1_q <= req_i.ctrl_count;
        for (int k = 0; k < 3; k++) begin
          r2_q[k] <= lerp_sum(base1_q[k], prod1_q[k]);
        end
        t2_q <= t1_q;
        cnt2_q <= cnt1_q;
        base3_q[0] <= r2_q[0];
        base3_q[1] <= r2_q[1];
        prod3_q[0] <= lerp_prod(r2_q[0], m0b, t2_q);
        prod3_q[1] <= lerp_prod(r2_q[1], r2_q[2], t2_q);
        t3_q <= t2_q;
        cnt3_q <= cnt2_q;
        r4_q[0] <= lerp_sum(base3_q[0], prod3_q[0]);
        r4_q[1] <= lerp_sum(base3_q[1], prod3_q[1]);
        t4_q <= t3_q;
        cnt4_q <= cnt3_q;
        base5_q <= r4_q[0];
        prod5_q <= lerp_prod(r4_q[0], f1b, t4_q);
        r6_q <= lerp_sum(base5_q, prod5_q);
      end
    end

    assign res[g] = r6_q;
  end

  assign pt_o.x = res[0];
  assign pt_o.y = res[1];
endmodule

/* hw/rtl/bph_deriv.sv */
// Six-stage tangent vector pipeline: line, quadratic and cubic derivative, cubic scaled down by 2^16 on overflow.
// Depends on bph_pkg.
module bph_deriv (
  input  logic            clk_i,
  input  logic            en_i,
  input  bph_pkg::req_t   req_i,
  output bph_pkg::dvec_t  vec_o
);
  import bph_pkg::*;

  localparam logic signed [51:0] HiLim = (52'sd1 <<< 46) - 52'sd1;

  logic [TW-1:0] t_c, u_c;
  logic signed [67:0] v5 [2];
  logic signed [63:0] e5 [2];
  logic signed [CoordW:0] l5 [2];
  cnt_e cnt5;
  logic signed [51:0] hi [2];
  logic fits [2];
  logic signed [VecW-1:0] sel [2];
  dvec_t vec_q;

  assign t_c = (req_i.t_param > TOne) ? TOne : req_i.t_param;
  assign u_c = TOne - t_c;

  for (genvar g = 0; g < 2; g++) begin : g_axis
    logic signed [CoordW-1:0] p0, c0, c1, p1;
    logic signed [CoordW:0] a1_q, b1_q, c1_q, l1_q, l2_q, l3_q, l4_q, l5_q;
    logic signed [50:0] pua_q, ptb_q, pub_q, ptc_q;
    logic signed [51:0] e0_q, e1_q, e4_q;
    logic [42:0] qul_q, qtl_q;
    logic signed [43:0] quh_q, qth_q;
    logic signed [44:0] hs;
    logic [43:0] ls;
    logic signed [67:0] v_q;
    logic signed [63:0] e5_q;
    logic [TW-1:0] t1_q, u1_q, t2_q, u2_q, t3_q, u3_q;
    cnt_e cnt1_q, cnt2_q, cnt3_q, cnt4_q, cnt5_q;

    assign p0 = (g == 0) ? req_i.start_x : req_i.start_y;
    assign c0 = (g == 0) ? req_i.ctrl0_x : req_i.ctrl0_y;
    assign c1 = (g == 0) ? req_i.ctrl1_x : req_i.ctrl1_y;
    assign p1 = (g == 0) ? req_i.end_x : req_i.end_y;
    assign hs = 45'(quh_q) + 45'(qth_q);
    assign ls = 44'(qul_q) + 44'(qtl_q);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a1_q <= (CoordW+1)'(c0) - (CoordW+1)'(p0);
        b1_q <= (req_i.ctrl_count == CntCubic) ? (CoordW+1)'(c1) - (CoordW+1)'(c0)
                                                : (CoordW+1)'(p1) - (CoordW+1)'(c0);
        c1_q <= (CoordW+1)'(p1) - (CoordW+1)'(c1);
        l1_q <= (CoordW+1)'(p1) - (CoordW+1)'(p0);
        t1_q <= t_c;
        u1_q <= u_c;
        cnt1_q <= req_i.ctrl_count;
        pua_q <= $signed({1'b0, u1_q}) * a1_q;
        ptb_q <= $signed({1'b0, t1_q}) * b1_q;
        pub_q <= $signed({1'b0, u1_q}) * b1_q;
        ptc_q <= $signed({1'b0, t1_q}) * c1_q;
        l2_q <= l1_q;
        t2_q <= t1_q;
        u2_q <= u1_q;
        cnt2_q <= cnt1_q;
        e0_q <= 52'(pua_q) + 52'(ptb_q);
        e1_q <= 52'(pub_q) + 52'(ptc_q);
        l3_q <= l2_q;
        t3_q <= t2_q;
        u3_q <= u2_q;
        cnt3_q <= cnt2_q;
        qul_q <= u3_q * e0_q[25:0];
        qtl_q <= t3_q * e1_q[25:0];
        quh_q <= $signed({1'b0, u3_q}) * $signed(e0_q[51:26]);
        qth_q <= $signed({1'b0, t3_q}) * $signed(e1_q[51:26]);
        e4_q <= e0_q;
        l4_q <= l3_q;
        cnt4_q <= cnt3_q;
        v_q <= (68'(hs) <<< 26) + 68'(ls);
        e5_q <= 64'(e4_q);
        l5_q <= l4_q;
        cnt5_q <= cnt4_q;
      end
    end

    assign v5[g] = v_q;
    assign e5[g] = e5_q;
    assign l5[g] = l5_q;
    if (g == 0) begin : g_cnt
      assign cnt5 = cnt5_q;
    end
  end

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      hi[g] = v5[g][67:16];
      fits[g] = (hi[g] <= HiLim) && (hi[g] >= -HiLim);
    end
    for (int g = 0; g < 2; g++) begin
      unique case (cnt5)
        CntQuad:  sel[g] = e5[g];
        CntCubic: sel[g] = (fits[0] && fits[1]) ? v5[g][63:0] : 64'(hi[g]);
        default:  sel[g] = 64'(l5[g]);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q.x <= sel[0];
      vec_q.y <= sel[1];
      vec_q.zero <= (sel[0] == '0) && (sel[1] == '0);
    end
  end

  assign vec_o = vec_q;
endmodule

/* hw/rtl/bph_norm.sv */
// Three-stage normalizer: magnitude, leading-one search, floor shift into CORDIC range.
// Depends on bph_pkg.
module bph_norm (
  input  logic            clk_i,
  input  logic            en_i,
  input  bph_pkg::dvec_t  vec_i,
  output bph_pkg::cvec_t  vec_o
);
  import bph_pkg::*;

  logic signed [VecW-1:0] x1_q, y1_q, x2_q, y2_q, xs, ys;
  logic [VecW-2:0] or1_q;
  logic [VecW-1:0] mx, my;
  logic [ShiftW-1:0] s_d, s2_q;
  cvec_t out_q;

  assign mx = vec_i.x[VecW-1] ? -vec_i.x : vec_i.x;
  assign my = vec_i.y[VecW-1] ? -vec_i.y : vec_i.y;

  always_comb begin
    s_d = '0;
    for (int i = NormTop; i < VecW - 1; i++) begin
      if (or1_q[i]) s_d = ShiftW'(i - NormTop + 1);
    end
  end

  assign xs = x2_q >>> s2_q;
  assign ys = y2_q >>> s2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= vec_i.x;
      y1_q <= vec_i.y;
      or1_q <= mx[VecW-2:0] | my[VecW-2:0];
      x2_q <= x1_q;
      y2_q <= y1_q;
      s2_q <= s_d;
      out_q.x <= xs[CordicW-1:0];
      out_q.y <= ys[CordicW-1:0];
    end
  end

  assign vec_o = out_q;
endmodule

/* hw/rtl/bph_cordic.sv */
// Vectoring CORDIC: quadrant fold stage, then two micro-rotations per stage.
// Depends on bph_pkg.
module bph_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  bph_pkg::cvec_t                    vec_i,
  output logic signed [bph_pkg::CordicW-1:0] acc_o
);
  import bph_pkg::*;

  localparam logic signed [CordicW-1:0] Quarter = CordicW'(1) <<< 30;

  logic signed [CordicW-1:0] xs [CordicStages+1];
  logic signed [CordicW-1:0] ys [CordicStages+1];
  logic signed [CordicW-1:0] as [CordicStages+1];
  logic signed [CordicW-1:0] x0_q, y0_q, a0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (vec_i.x < 0) begin
        if (vec_i.y >= 0) begin
          x0_q <= vec_i.y;
          y0_q <= -vec_i.x;
          a0_q <= Quarter;
        end else begin
          x0_q <= -vec_i.y;
          y0_q <= vec_i.x;
          a0_q <= -Quarter;
        end
      end else begin
        x0_q <= vec_i.x;
        y0_q <= vec_i.y;
        a0_q <= '0;
      end
    end
  end

  assign xs[0] = x0_q;
  assign ys[0] = y0_q;
  assign as[0] = a0_q;

  for (genvar k = 0; k < CordicStages; k++) begin : g_stage
    logic signed [CordicW-1:0] xn, yn, an, dx, dy;
    logic signed [CordicW-1:0] x_q, y_q, a_q;

    always_comb begin
      xn = xs[k];
      yn = ys[k];
      an = as[k];
      for (int j = 0; j < CordicPerStage; j++) begin
        dx = yn >>> (k * CordicPerStage + j);
        dy = xn >>> (k * CordicPerStage + j);
        if (yn > 0) begin
          xn = xn + dx;
          yn = yn - dy;
          an = an + atan_lut(k * CordicPerStage + j);
        end else begin
          xn = xn - dx;
          yn = yn + dy;
          an = an - atan_lut(k * CordicPerStage + j);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q <= xn;
        y_q <= yn;
        a_q <= an;
      end
    end

    assign xs[k+1] = x_q;
    assign ys[k+1] = y_q;
    assign as[k+1] = a_q;
  end

  assign acc_o = as[CordicStages];
endmodule

/* hw/rtl/bph_checker.sv */
// Port-level checks of the Bezier point and heading unit, bound to its top level.
// Depends on bph_pkg for field widths.
module bph_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic signed [bph_pkg::CoordW-1:0] point_x_i,
  input logic signed [bph_pkg::CoordW-1:0] point_y_i,
  input logic signed [bph_pkg::HeadW-1:0]  heading_i
);

  a_ready_follows_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i == (!rsp_valid_i || rsp_ready_i))
    else $error("request ready does not follow output stall");

  a_reset_empties : assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("result valid during reset");

  a_valid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_payload_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(point_x_i) && $stable(point_y_i)
      && $stable(heading_i))
    else $error("result changed while stalled");

endmodule

bind bezier_point_and_heading_unit bph_checker u_bph_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .point_x_i  (rsp_o.point_x),
  .point_y_i  (rsp_o.point_y),
  .heading_i  (rsp_o.heading)
);
